### hdl/sqct_pkg.sv
// Shared types, constants and helpers for the sprite quad corner transform.
`default_nettype none
package sqct_pkg;

  localparam logic [1:0] ALIGN_CENTRE = 2'd1;
  localparam logic [1:0] ALIGN_END    = 2'd2;

  localparam logic [1:0] CORNER_LAST  = 2'd3;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_SRC = 1'b1;

  // One sprite as set up by the front end, positions in 1/32 units.
  typedef struct packed {
    logic               err;
    logic signed [19:0] lx0;
    logic signed [19:0] lx1;
    logic signed [19:0] ly0;
    logic signed [19:0] ly1;
    logic signed [19:0] spx;
    logic signed [19:0] spy;
    logic signed [19:0] pvx;
    logic signed [19:0] pvy;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] scx;
    logic signed [15:0] scy;
    logic signed [15:0] c;
    logic signed [15:0] s;
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic        [16:0] u0;
    logic        [16:0] u1;
    logic        [16:0] v0;
    logic        [16:0] v1;
    logic        [15:0] layer;
  } sprite_t;

  // Per-corner data carried alongside the arithmetic.
  typedef struct packed {
    logic               err;
    logic               last;
    logic        [1:0]  idx;
    logic        [16:0] u;
    logic        [16:0] v;
    logic        [15:0] z;
    logic signed [19:0] px;
    logic signed [19:0] py;
  } tag_t;

  // Alignment offset in 1/32 units from a length in 1/16 units.
  function automatic logic signed [19:0] align_off(input logic [1:0] code,
                                                   input logic [15:0] len);
    logic signed [19:0] r;
    case (code)
      ALIGN_CENTRE: r = $signed({4'b0, len});
      ALIGN_END:    r = $signed({3'b0, len, 1'b0});
      default:      r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/sprite_quad_corner_transform_core.sv
// Sprite quad corner transform: top level joining front end, queue and back end.
//
// Input channel (in_valid/in_ready) takes one sprite per item; the result
// channel (out_valid/out_ready) gives its corners top-left, top-right,
// bottom-left, bottom-right, out_last marking the final one. A sprite with a
// zero source width or height gives one result with out_status and out_last
// set and all else zero; another sprite of zero width or height gives nothing.
// The back end issues one corner per cycle, while the output is not stalled,
// into its four-stage skew/scale/rotate/round pipeline and pops a sprite
// from the queue with its last corner; a bad-source sprite issues only its
// single result. A front register and a two-entry queue let new sprites be
// taken while corners are still in flight.
// When out_ready is low with a result waiting, the whole back pipeline holds;
// the front keeps taking sprites until queue and front register are full, then
// drops in_ready. Reset (rst_n low, synchronous) empties the front register,
// queue and pipeline and clears the corner count; there is no other state.
`default_nettype none
module sprite_quad_corner_transform_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [19:0] in_pos_x,
  input  wire logic [19:0] in_pos_y,
  input  wire logic [31:0] in_size_wh,
  input  wire logic [31:0] in_scale_xy,
  input  wire logic [15:0] in_rot_cos,
  input  wire logic [15:0] in_rot_sin,
  input  wire logic [31:0] in_skew_tan_xy,
  input  wire logic [13:0] in_align_flip,
  input  wire logic [31:0] in_src_uv,
  input  wire logic [31:0] in_src_wh,
  input  wire logic [15:0] in_layer,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [19:0]      out_corner_x,
  output logic [19:0]      out_corner_y,
  output logic [15:0]      out_corner_z,
  output logic [16:0]      out_tex_u,
  output logic [16:0]      out_tex_v,
  output logic [1:0]       out_corner_index,
  output logic             out_status,
  output logic             out_last
);
  import sqct_pkg::*;

  logic    f_valid, f_ready, q_valid, q_pop;
  sprite_t f_data, q_data;

  sqct_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_pos_x, .in_pos_y, .in_size_wh, .in_scale_xy, .in_rot_cos, .in_rot_sin,
    .in_skew_tan_xy, .in_align_flip, .in_src_uv, .in_src_wh, .in_layer,
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  sqct_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_pop(q_pop), .rd_data(q_data)
  );

  sqct_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid, .out_ready, .out_corner_x, .out_corner_y, .out_corner_z,
    .out_tex_u, .out_tex_v, .out_corner_index, .out_status, .out_last
  );

endmodule
`default_nettype wire

### hdl/sqct_front.sv
// Front end: takes sprites, sorts out empty and bad-source ones, sets up geometry.
`default_nettype none
module sqct_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [19:0]       in_pos_x,
  input  wire logic [19:0]       in_pos_y,
  input  wire logic [31:0]       in_size_wh,
  input  wire logic [31:0]       in_scale_xy,
  input  wire logic [15:0]       in_rot_cos,
  input  wire logic [15:0]       in_rot_sin,
  input  wire logic [31:0]       in_skew_tan_xy,
  input  wire logic [13:0]       in_align_flip,
  input  wire logic [31:0]       in_src_uv,
  input  wire logic [31:0]       in_src_wh,
  input  wire logic [15:0]       in_layer,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output sqct_pkg::sprite_t      q_data
);
  import sqct_pkg::*;

  logic    fr_valid_r, fr_valid_nxt;
  sprite_t fr_r, fr_nxt;
  logic [15:0] w, h, su, sv, sw, sh;
  logic signed [19:0] ax, ay;
  logic bad_src, empty;

  assign in_ready = !fr_valid_r || q_ready;
  assign q_valid  = fr_valid_r;
  assign q_data   = fr_r;

  always_comb begin
    w  = in_size_wh[15:0];
    h  = in_size_wh[31:16];
    su = in_src_uv[15:0];
    sv = in_src_uv[31:16];
    sw = in_src_wh[15:0];
    sh = in_src_wh[31:16];
    bad_src = (sw == '0) || (sh == '0);
    empty   = (w == '0) || (h == '0);
    ax = align_off(in_align_flip[1:0], w);
    ay = align_off(in_align_flip[3:2], h);

    fr_nxt.err   = bad_src;
    fr_nxt.lx0   = -ax;
    fr_nxt.lx1   = $signed({3'b0, w, 1'b0}) - ax;
    fr_nxt.ly0   = -ay;
    fr_nxt.ly1   = $signed({3'b0, h, 1'b0}) - ay;
    fr_nxt.pvx   = align_off(in_align_flip[5:4], w) - ax;
    fr_nxt.pvy   = align_off(in_align_flip[7:6], h) - ay;
    fr_nxt.spx   = align_off(in_align_flip[9:8], w) - ax;
    fr_nxt.spy   = align_off(in_align_flip[11:10], h) - ay;
    fr_nxt.tx    = $signed(in_skew_tan_xy[15:0]);
    fr_nxt.ty    = $signed(in_skew_tan_xy[31:16]);
    fr_nxt.scx   = $signed(in_scale_xy[15:0]);
    fr_nxt.scy   = $signed(in_scale_xy[31:16]);
    fr_nxt.c     = $signed(in_rot_cos);
    fr_nxt.s     = $signed(in_rot_sin);
    fr_nxt.px    = $signed(in_pos_x);
    fr_nxt.py    = $signed(in_pos_y);
    fr_nxt.u0    = in_align_flip[12] ? {1'b0, su} + {1'b0, sw} : {1'b0, su};
    fr_nxt.u1    = in_align_flip[12] ? {1'b0, su} : {1'b0, su} + {1'b0, sw};
    fr_nxt.v0    = in_align_flip[13] ? {1'b0, sv} + {1'b0, sh} : {1'b0, sv};
    fr_nxt.v1    = in_align_flip[13] ? {1'b0, sv} : {1'b0, sv} + {1'b0, sh};
    fr_nxt.layer = in_layer;

    fr_valid_nxt = fr_valid_r && !q_ready;
    if (in_valid && in_ready) begin
      // an empty sprite with a good source gives nothing
      fr_valid_nxt = bad_src || !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_r <= fr_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/sqct_fifo.sv
// Two-entry sprite queue between front and back ends.
`default_nettype none
module sqct_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire sqct_pkg::sprite_t wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_pop,
  output sqct_pkg::sprite_t      rd_data
);
  import sqct_pkg::*;

  sprite_t    mem_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### hdl/sqct_back.sv
// Back end: steps through the corners and runs the skew/scale/rotate pipeline.
`default_nettype none
module sqct_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire sqct_pkg::sprite_t q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [19:0]            out_corner_x,
  output logic [19:0]            out_corner_y,
  output logic [15:0]            out_corner_z,
  output logic [16:0]            out_tex_u,
  output logic [16:0]            out_tex_v,
  output logic [1:0]             out_corner_index,
  output logic                   out_status,
  output logic                   out_last
);
  import sqct_pkg::*;

  localparam logic signed [53:0] HALF20 = 54'sd524288;
  localparam logic signed [50:0] HALF19 = 51'sd262144;
  localparam logic signed [32:0] XY_MAX = 33'sd524287;
  localparam logic signed [32:0] XY_MIN = -33'sd524288;

  logic adv;
  logic [1:0] k_r, k_nxt;

  // stage 1: skewed corner, units of 2^-17
  logic               s1_valid_r;
  tag_t               s1_tag_r, s1_tag_nxt;
  logic signed [37:0] s1_x_r, s1_y_r, s1_x_nxt, s1_y_nxt;
  logic signed [15:0] s1_scx_r, s1_scy_r, s1_c_r, s1_s_r;
  // stage 2: scaled, Q.9
  logic               s2_valid_r;
  tag_t               s2_tag_r;
  logic signed [33:0] s2_x_r, s2_y_r, s2_x_nxt, s2_y_nxt;
  logic signed [15:0] s2_c_r, s2_s_r;
  // stage 3: rotation products
  logic               s3_valid_r;
  tag_t               s3_tag_r;
  logic signed [49:0] s3_xc_r, s3_ys_r, s3_xs_r, s3_yc_r;
  // output register
  logic               out_valid_r;
  logic [19:0]        ox_nxt, oy_nxt;

  logic signed [20:0] x, y, dx, dy;
  logic signed [36:0] txy, tyx;
  logic signed [53:0] psx, psy;
  logic signed [50:0] rxf, ryf;
  logic signed [31:0] rx, ry;
  logic signed [32:0] sx, sy;
  logic ix, iy;

  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = adv && q_valid && (q_data.err || (k_r == CORNER_LAST));
  assign out_valid = out_valid_r;

  always_comb begin
    ix  = k_r[0];
    iy  = k_r[1];
    x   = 21'(ix ? q_data.lx1 : q_data.lx0) - 21'(q_data.spx);
    y   = 21'(iy ? q_data.ly1 : q_data.ly0) - 21'(q_data.spy);
    dx  = 21'(q_data.spx) - 21'(q_data.pvx);
    dy  = 21'(q_data.spy) - 21'(q_data.pvy);
    txy = q_data.tx * y;
    tyx = q_data.ty * x;
    s1_x_nxt = (38'(x) <<< 12) + 38'(txy) + (38'(dx) <<< 12);
    s1_y_nxt = (38'(y) <<< 12) + 38'(tyx) + (38'(dy) <<< 12);
    s1_tag_nxt.err  = q_data.err;
    s1_tag_nxt.last = q_data.err || (k_r == CORNER_LAST);
    s1_tag_nxt.idx  = q_data.err ? 2'd0 : k_r;
    s1_tag_nxt.u    = ix ? q_data.u1 : q_data.u0;
    s1_tag_nxt.v    = iy ? q_data.v1 : q_data.v0;
    s1_tag_nxt.z    = q_data.layer;
    s1_tag_nxt.px   = q_data.px;
    s1_tag_nxt.py   = q_data.py;

    k_nxt = k_r;
    if (q_pop) begin
      k_nxt = 2'd0;
    end else if (adv && q_valid) begin
      k_nxt = k_r + 2'd1;
    end

    psx = s1_x_r * s1_scx_r;
    psy = s1_y_r * s1_scy_r;
    s2_x_nxt = 34'((psx + HALF20) >>> 20);
    s2_y_nxt = 34'((psy + HALF20) >>> 20);

    rxf = 51'(s3_xc_r) - 51'(s3_ys_r) + HALF19;
    ryf = 51'(s3_xs_r) + 51'(s3_yc_r) + HALF19;
    rx  = 32'(rxf >>> 19);
    ry  = 32'(ryf >>> 19);
    sx  = 33'(s3_tag_r.px) + 33'(rx);
    sy  = 33'(s3_tag_r.py) + 33'(ry);
    if (sx > XY_MAX)      ox_nxt = XY_MAX[19:0];
    else if (sx < XY_MIN) ox_nxt = XY_MIN[19:0];
    else                  ox_nxt = sx[19:0];
    if (sy > XY_MAX)      oy_nxt = XY_MAX[19:0];
    else if (sy < XY_MIN) oy_nxt = XY_MIN[19:0];
    else                  oy_nxt = sy[19:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 2'd0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      k_r <= k_nxt;
      if (adv) begin
        s1_valid_r  <= q_valid;
        s2_valid_r  <= s1_valid_r;
        s3_valid_r  <= s2_valid_r;
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag_r <= s1_tag_nxt;
      s1_x_r   <= s1_x_nxt;
      s1_y_r   <= s1_y_nxt;
      s1_scx_r <= q_data.scx;
      s1_scy_r <= q_data.scy;
      s1_c_r   <= q_data.c;
      s1_s_r   <= q_data.s;
      s2_tag_r <= s1_tag_r;
      s2_x_r   <= s2_x_nxt;
      s2_y_r   <= s2_y_nxt;
      s2_c_r   <= s1_c_r;
      s2_s_r   <= s1_s_r;
      s3_tag_r <= s2_tag_r;
      s3_xc_r  <= s2_x_r * s2_c_r;
      s3_ys_r  <= s2_y_r * s2_s_r;
      s3_xs_r  <= s2_x_r * s2_s_r;
      s3_yc_r  <= s2_y_r * s2_c_r;
      // a bad source rectangle reports zeros with status set
      out_corner_x     <= s3_tag_r.err ? '0 : ox_nxt;
      out_corner_y     <= s3_tag_r.err ? '0 : oy_nxt;
      out_corner_z     <= s3_tag_r.err ? '0 : s3_tag_r.z;
      out_tex_u        <= s3_tag_r.err ? '0 : s3_tag_r.u;
      out_tex_v        <= s3_tag_r.err ? '0 : s3_tag_r.v;
      out_corner_index <= s3_tag_r.idx;
      out_status       <= s3_tag_r.err ? STATUS_BAD_SRC : STATUS_OK;
      out_last         <= s3_tag_r.last;
    end
  end

endmodule
`default_nettype wire

### hdl/sqct_checker.sv
// Port-level checks on the result channel, bound to the top level.
`default_nettype none
module sqct_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [19:0] out_corner_x,
  input wire logic [1:0]  out_corner_index,
  input wire logic        out_status,
  input wire logic        out_last
);
  import sqct_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_corner_x) && $stable(out_last))
    else $error("result dropped or changed while stalled");

  a_bad_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_BAD_SRC) |-> out_last && (out_corner_index == 2'd0))
    else $error("bad-source result not single");

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_OK) && (out_corner_index == CORNER_LAST) |-> out_last)
    else $error("bottom-right corner not marked last");

  a_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_OK) && out_last |-> out_corner_index == CORNER_LAST)
    else $error("last marked on an inner corner");

endmodule

bind sprite_quad_corner_transform_core sqct_port_checker u_sqct_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_corner_x,
  .out_corner_index, .out_status, .out_last
);
`default_nettype wire

### dv/sqct_checker.sv
// Checker for the sprite quad corner transform: predicts corners and compares results.
`timescale 1ns / 1ps
`default_nettype none
module sqct_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [19:0] in_pos_x,
  input  wire logic [19:0] in_pos_y,
  input  wire logic [31:0] in_size_wh,
  input  wire logic [31:0] in_scale_xy,
  input  wire logic [15:0] in_rot_cos,
  input  wire logic [15:0] in_rot_sin,
  input  wire logic [31:0] in_skew_tan_xy,
  input  wire logic [13:0] in_align_flip,
  input  wire logic [31:0] in_src_uv,
  input  wire logic [31:0] in_src_wh,
  input  wire logic [15:0] in_layer,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [19:0] out_corner_x,
  input  wire logic [19:0] out_corner_y,
  input  wire logic [15:0] out_corner_z,
  input  wire logic [16:0] out_tex_u,
  input  wire logic [16:0] out_tex_v,
  input  wire logic [1:0]  out_corner_index,
  input  wire logic        out_status,
  input  wire logic        out_last,
  output int               fail_count,
  output int               corners_pending
);
  import sqct_pkg::*;

  typedef struct packed {
    logic [19:0] x;
    logic [19:0] y;
    logic [15:0] z;
    logic [16:0] u;
    logic [16:0] v;
    logic [1:0]  idx;
    logic        status;
    logic        last;
  } corner_t;

  corner_t expected_corners[$];

  assign corners_pending = expected_corners.size();

  function automatic longint align_len(input logic [1:0] code, input longint len);
    case (code)
      ALIGN_CENTRE: return len;
      ALIGN_END:    return 2 * len;
      default:      return 0;
    endcase
  endfunction

  // arithmetic shift on longint floors, so adding half gives round half up
  function automatic longint round_down(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic logic [19:0] clamp20(input longint v);
    if (v > 524287) return 20'h7FFFF;
    if (v < -524288) return 20'h80000;
    return v[19:0];
  endfunction

  task automatic predict_corners();
    longint px, py, w, h, scx, scy, c, s, tx, ty;
    longint ax, ay, pvx, pvy, spx, spy, x, y, bx, by, rx, ry;
    longint lx[2], ly[2];
    logic [16:0] u[2], v[2];
    logic [13:0] af;
    corner_t cr;
    af = in_align_flip;
    px = longint'($signed(in_pos_x));
    py = longint'($signed(in_pos_y));
    w = longint'(in_size_wh[15:0]);
    h = longint'(in_size_wh[31:16]);
    scx = longint'($signed(in_scale_xy[15:0]));
    scy = longint'($signed(in_scale_xy[31:16]));
    c = longint'($signed(in_rot_cos));
    s = longint'($signed(in_rot_sin));
    tx = longint'($signed(in_skew_tan_xy[15:0]));
    ty = longint'($signed(in_skew_tan_xy[31:16]));
    if (in_src_wh[15:0] == 0 || in_src_wh[31:16] == 0) begin
      cr = '0;
      cr.status = STATUS_BAD_SRC;
      cr.last = 1'b1;
      expected_corners.push_back(cr);
      return;
    end
    if (w == 0 || h == 0) return;
    ax = align_len(af[1:0], w);
    ay = align_len(af[3:2], h);
    lx[0] = -ax; lx[1] = 2 * w - ax;
    ly[0] = -ay; ly[1] = 2 * h - ay;
    pvx = align_len(af[5:4], w) - ax;
    pvy = align_len(af[7:6], h) - ay;
    spx = align_len(af[9:8], w) - ax;
    spy = align_len(af[11:10], h) - ay;
    u[0] = af[12] ? 17'(in_src_uv[15:0]) + in_src_wh[15:0] : 17'(in_src_uv[15:0]);
    u[1] = af[12] ? 17'(in_src_uv[15:0]) : 17'(in_src_uv[15:0]) + in_src_wh[15:0];
    v[0] = af[13] ? 17'(in_src_uv[31:16]) + in_src_wh[31:16] : 17'(in_src_uv[31:16]);
    v[1] = af[13] ? 17'(in_src_uv[31:16]) : 17'(in_src_uv[31:16]) + in_src_wh[31:16];
    for (int k = 0; k < 4; k++) begin
      x = lx[k & 1] - spx;
      y = ly[k >> 1] - spy;
      bx = round_down((x * 4096 + tx * y + (spx - pvx) * 4096) * scx, 20);
      by = round_down((y * 4096 + ty * x + (spy - pvy) * 4096) * scy, 20);
      rx = round_down(bx * c - by * s, 19);
      ry = round_down(bx * s + by * c, 19);
      cr.x = clamp20(px + rx);
      cr.y = clamp20(py + ry);
      cr.z = in_layer;
      cr.u = u[k & 1];
      cr.v = v[k >> 1];
      cr.idx = 2'(k);
      cr.status = STATUS_OK;
      cr.last = (k == 3);
      expected_corners.push_back(cr);
    end
  endtask

  always @(posedge clk) begin
    corner_t want, got;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) predict_corners();
      if (out_valid && out_ready) begin
        got = '{out_corner_x, out_corner_y, out_corner_z, out_tex_u, out_tex_v,
                out_corner_index, out_status, out_last};
        if (expected_corners.size() == 0) begin
          if (fail_count < 10) $display("unexpected corner %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_corners.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("corner mismatch: exp x=%h y=%h z=%h u=%h v=%h i=%0d st=%b l=%b, got x=%h y=%h z=%h u=%h v=%h i=%0d st=%b l=%b",
                       want.x, want.y, want.z, want.u, want.v, want.idx, want.status,
                       want.last, got.x, got.y, got.z, got.u, got.v, got.idx,
                       got.status, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### dv/tb_sprite_quad_corner_transform_core.sv
// Testbench top for the sprite quad corner transform: stimulus, idling and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_sprite_quad_corner_transform_core;
  import sqct_pkg::*;

  localparam int RANDOM_SPRITES = 260;
  localparam int CYCLE_LIMIT = 200000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [19:0] in_pos_x, in_pos_y;
  logic [31:0] in_size_wh, in_scale_xy, in_skew_tan_xy, in_src_uv, in_src_wh;
  logic [15:0] in_rot_cos, in_rot_sin, in_layer;
  logic [13:0] in_align_flip;
  logic [19:0] out_corner_x, out_corner_y;
  logic [15:0] out_corner_z;
  logic [16:0] out_tex_u, out_tex_v;
  logic [1:0]  out_corner_index;
  logic        out_status, out_last;
  int fail_count, corners_pending;
  int cycles = 0;
  bit calm, hold_done;

  sprite_quad_corner_transform_core i_dut (.*);
  sqct_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: one long hold-off early on, then random stall bursts
  initial begin
    int n;
    out_ready = 0;
    hold_done = 0;
    @(posedge clk iff rst_n);
    repeat (20) @(posedge clk);
    repeat (150) @(posedge clk);
    hold_done = 1;
    forever begin
      n = $urandom_range(1, 17);
      if (!calm && $urandom_range(0, 2) == 0) out_ready <= 0;
      else out_ready <= 1;
      repeat (n) @(posedge clk);
    end
  end

  task automatic offer_sprite(input logic [19:0] px, py, input logic [31:0] size, scale,
                              input logic [15:0] c, s, input logic [31:0] tan,
                              input logic [13:0] af, input logic [31:0] uv, wh,
                              input logic [15:0] layer);
    in_valid <= 1;
    in_pos_x <= px; in_pos_y <= py; in_size_wh <= size; in_scale_xy <= scale;
    in_rot_cos <= c; in_rot_sin <= s; in_skew_tan_xy <= tan; in_align_flip <= af;
    in_src_uv <= uv; in_src_wh <= wh; in_layer <= layer;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h1000;
      3: return 16'($signed($urandom_range(0, 8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] ang_c, ang_s;
    calm = 0;
    rst_n = 0;
    in_valid = 0;
    {in_pos_x, in_pos_y, in_size_wh, in_scale_xy, in_rot_cos, in_rot_sin} = '0;
    {in_skew_tan_xy, in_align_flip, in_src_uv, in_src_wh, in_layer} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // directed: identity, alignments, flips, extremes, bad source, empty sprite
    offer_sprite(0, 0, {16'd160, 16'd320}, 32'h1000_1000, 16'h4000, 0, 0, 0,
                 {16'd16, 16'd32}, {16'd64, 16'd64}, 16'd7);
    offer_sprite(20'h00100, 20'h00200, {16'd48, 16'd33}, 32'h1000_1000, 16'h4000, 0, 0,
                 14'b00_010101_010101, {16'd5, 16'd9}, {16'd20, 16'd30}, 16'hFFFF);
    offer_sprite(20'h7FFFF, 20'h80000, 32'hFFFF_FFFF, 32'h7FFF_7FFF, 16'h4000, 16'hC000,
                 32'h7FFF_8000, 14'h3FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    offer_sprite(20'h80000, 20'h7FFFF, 32'hFFFF_FFFF, 32'h8000_8000, 16'h8000, 16'h7FFF,
                 32'h8000_7FFF, 14'h2AAA, 32'h0, 32'h0001_0001, 16'h1234);
    offer_sprite(20'h12345, 20'h54321, {16'd80, 16'd80}, 32'h2000_0800, 16'h2D41,
                 16'h2D41, 32'h0400_FC00, 14'h1000 | 14'h0222, {16'd3, 16'd3},
                 {16'd8, 16'd8}, 16'd1);
    offer_sprite(0, 0, {16'd16, 16'd16}, 32'h1000_1000, 16'h4000, 0, 0, 0,
                 0, {16'd8, 16'd0}, 16'd9);
    offer_sprite(0, 0, {16'd16, 16'd16}, 32'h1000_1000, 16'h4000, 0, 0, 0,
                 0, {16'd0, 16'd8}, 16'd9);
    offer_sprite(0, 0, {16'd0, 16'd16}, 32'h1000_1000, 16'h4000, 0, 0, 0,
                 0, {16'd8, 16'd8}, 16'd9);
    offer_sprite(0, 0, {16'd16, 16'd0}, 32'h1000_1000, 16'h4000, 0, 0, 0,
                 0, {16'd8, 16'd8}, 16'd9);
    offer_sprite(20'h00001, 20'hFFFFF, {16'd1, 16'd1}, 32'hFFFF_0001, 16'hC000, 16'h4000,
                 32'h0001_FFFF, 14'h3333, 32'h8000_8000, 32'h8000_8000, 16'h8000);
    for (int i = 0; i < RANDOM_SPRITES; i++) begin
      if (i > RANDOM_SPRITES - 40) calm = 1;
      ang_c = pick16();
      ang_s = pick16();
      offer_sprite(20'($urandom), 20'($urandom),
                   ($urandom_range(0, 3) == 0) ? $urandom :
                     {16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024))},
                   {pick16(), pick16()}, ang_c, ang_s,
                   ($urandom_range(0, 1) == 0) ? 32'h0 : {pick16(), pick16()},
                   14'($urandom),
                   $urandom,
                   ($urandom_range(0, 15) == 0) ? ($urandom & 32'hFFFF_0000) : $urandom,
                   16'($urandom));
    end
    in_valid <= 0;
    wait (hold_done);
    @(posedge clk);
    while (corners_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && corners_pending == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
